### rtl/pdga_pkg.sv
// ============================================================================
// pdga_pkg: shared types and constants of the Poisson-disk grid accept core
// Holds the sequencer state type, result status codes, configuration register
// indexes and the neighbor offset table.
// ============================================================================
`default_nettype none

package pdga_pkg;

    // Sequencer states of the accept core.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP_X,
        S_MAP_Y,
        S_MAP_ROW,
        S_CTR_READ,
        S_CTR_CHECK,
        S_NBR_ADDR,
        S_NBR_OWNER,
        S_NBR_DIFF,
        S_NBR_SQX,
        S_NBR_SQY,
        S_NBR_CMP,
        S_DECIDE,
        S_FINISH
    } t_state;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_ACCEPT   = 2'd0;
    localparam t_status ST_OCCUPIED = 2'd1;
    localparam t_status ST_CLOSE    = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_GRID_DIM     = 3'd0;
    localparam t_cfg_index CFG_CELL_SCALE   = 3'd1;
    localparam t_cfg_index CFG_DIST_LIMIT   = 3'd2;
    localparam t_cfg_index CFG_SAMPLE_LIMIT = 3'd3;

    // Reset values of the configuration registers.
    localparam logic [6:0]  GRID_DIM_RST     = 7'd64;
    localparam logic [22:0] CELL_SCALE_RST   = 23'd4194304;
    localparam logic [33:0] DIST_LIMIT_RST   = 34'd0;
    localparam logic [12:0] SAMPLE_LIMIT_RST = 13'd4096;

    // Column and row offset of neighbor k, as two's complement -1, 0 or +1.
    // Neighbors run row by row from the upper left, skipping the center cell.
    function automatic logic [1:0] nbr_dx(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd0, 3'd3, 3'd5: d = 2'b11;
            3'd1, 3'd6:       d = 2'b00;
            default:          d = 2'b01;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] nbr_dy(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd0, 3'd1, 3'd2: d = 2'b11;
            3'd3, 3'd4:       d = 2'b00;
            default:          d = 2'b01;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/poisson_disk_grid_accept_core.sv
// ============================================================================
// poisson_disk_grid_accept_core: Poisson-disk sampling acceptance stage
// Maps a candidate point to a background-grid cell, checks the cell and its
// eight neighbors for conflicting samples and stores the point if it passes.
// ============================================================================
// One request is handled at a time by a small sequencer around a single shared
// multiplier and single-port reads of the cell-owner and sample memories. From
// acceptance to result a request passes through the cell mapping and the center
// check, then visits each neighbor in turn: one outside the grid is skipped, one
// whose cell is empty needs only the owner read, and one that holds a stored
// sample has that sample fetched and its squared distance formed. A decide step
// and a finish step then post the result. An occupied center cell skips the walk,
// and a neighbor that is too close ends the walk at once, so the time taken is
// set by the serial walk over the neighbor cells. A result waits in an output
// register, so a new request is taken in the idle cycle that follows; while an
// earlier result is still held there, the sequencer waits before posting. After
// reset the cell-owner memory is cleared one cell per cycle over all GRID_DIM *
// GRID_DIM cells, during which no request is taken; configuration writes are
// accepted at any time.
`default_nettype none

module poisson_disk_grid_accept_core #(
    parameter int GRID_DIM = 64,
    parameter int CAPACITY = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [33:0] i_cfg_data,
    // Candidate channel.
    input  wire logic        i_cand_valid,
    output logic             o_cand_stall,
    input  wire logic [16:0] i_cand_x,
    input  wire logic [16:0] i_cand_y,
    // Result channel.
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic             o_accepted,
    output logic [1:0]       o_status,
    output logic [11:0]      o_sample_index,
    output logic [5:0]       o_cell_col,
    output logic [5:0]       o_cell_row
);

    // Derived widths.
    localparam int CW    = $clog2(GRID_DIM);             // column / row
    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(CELLS);                // cell address
    localparam int IW    = $clog2(CAPACITY);             // sample index
    localparam int NW    = $clog2(CAPACITY + 1);         // sample count
    localparam int SW    = 9;                            // saturation compares
    localparam int OW    = IW + 1;                       // owner entry

    // Configuration registers.
    logic [6:0]  r_grid_dim;
    logic [22:0] r_cell_scale;
    logic [33:0] r_dist_limit;
    logic [12:0] r_sample_limit;

    // Sequencer and bookkeeping.
    pdga_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr;
    logic [2:0]       r_k;
    logic [NW-1:0]    r_count;

    // Request payload and working registers.
    logic [16:0]       r_x, r_y;
    logic [39:0]       r_prod;
    logic [CW-1:0]     r_col, r_row;
    logic [16:0]       r_dx, r_dy;
    logic [33:0]       r_acc;
    pdga_pkg::t_status r_status;

    // Memories and their registered read data.
    logic [OW-1:0] r_owner [CELLS];
    logic [33:0]   r_store [CAPACITY];
    logic [OW-1:0] r_own_rd;
    logic [33:0]   r_smp_rd;

    // Result register.
    logic              r_out_valid;
    logic              r_out_accepted;
    pdga_pkg::t_status r_out_status;
    logic [11:0]       r_out_index;
    logic [5:0]        r_out_col, r_out_row;

    // Datapath control.
    logic [16:0]   mul_a;
    logic [22:0]   mul_b;
    logic [39:0]   w_prod;
    logic [AW-1:0] own_rd_addr;
    logic          own_we;
    logic [AW-1:0] own_wr_addr;
    logic [OW-1:0] own_wr_data;
    logic          smp_we;
    logic          ld_col, ld_row, ld_diff, ld_acc;
    logic          set_status;
    pdga_pkg::t_status status_val;
    logic          k_clear, k_step;
    logic          cnt_inc;
    logic          out_load;

    // Effective grid size and sample limit after clamping.
    logic [SW-1:0] eff_dim, eff_dim_m1;
    logic [NW-1:0] eff_limit;
    logic [SW-1:0] sat_cell;
    logic          store_full;

    always_comb begin
        if (r_grid_dim == 7'd0) begin
            eff_dim = SW'(1);
        end else if (32'(r_grid_dim) > GRID_DIM) begin
            eff_dim = SW'(GRID_DIM);
        end else begin
            eff_dim = SW'(r_grid_dim);
        end
        eff_dim_m1 = eff_dim - SW'(1);
        if (r_sample_limit == 13'd0) begin
            eff_limit = NW'(1);
        end else if (32'(r_sample_limit) > CAPACITY) begin
            eff_limit = NW'(CAPACITY);
        end else begin
            eff_limit = NW'(r_sample_limit);
        end
        store_full = (r_count >= eff_limit);
    end

    // Cell index from the last product, saturated to the last cell in use.
    always_comb begin
        if ({1'b0, r_prod[39:32]} > eff_dim_m1) begin
            sat_cell = eff_dim_m1;
        end else begin
            sat_cell = {1'b0, r_prod[39:32]};
        end
    end

    // Shared multiplier.
    assign w_prod = {23'd0, mul_a} * {17'd0, mul_b};

    // Neighbor position and whether it lies inside the grid in use.
    logic [1:0]    nb_dx, nb_dy;
    logic [CW+1:0] nb_col, nb_row;
    logic          nb_inside;
    logic [AW-1:0] ctr_addr, nb_addr;

    always_comb begin
        nb_dx  = pdga_pkg::nbr_dx(r_k);
        nb_dy  = pdga_pkg::nbr_dy(r_k);
        nb_col = {2'b00, r_col} + {{CW{nb_dx[1]}}, nb_dx};
        nb_row = {2'b00, r_row} + {{CW{nb_dy[1]}}, nb_dy};
        nb_inside = !nb_col[CW+1] && !nb_row[CW+1]
                    && (SW'(nb_col) < eff_dim) && (SW'(nb_row) < eff_dim);
        ctr_addr = AW'(r_row) * AW'(GRID_DIM) + AW'(r_col);
        nb_addr  = AW'(nb_row[CW-1:0]) * AW'(GRID_DIM) + AW'(nb_col[CW-1:0]);
    end

    // Absolute coordinate differences and the squared distance.
    logic [16:0] abs_dx, abs_dy;
    logic [34:0] dist_sum;

    always_comb begin
        abs_dx = (r_x >= r_smp_rd[33:17]) ? r_x - r_smp_rd[33:17] : r_smp_rd[33:17] - r_x;
        abs_dy = (r_y >= r_smp_rd[16:0]) ? r_y - r_smp_rd[16:0] : r_smp_rd[16:0] - r_y;
        dist_sum = {1'b0, r_acc} + {1'b0, r_prod[33:0]};
    end

    logic out_free;
    logic own_hit;
    assign out_free = !r_out_valid || !i_res_stall;
    assign own_hit  = r_own_rd[OW-1];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdga_pkg::S_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) n_state = pdga_pkg::S_IDLE;
            end
            pdga_pkg::S_IDLE: begin
                if (i_cand_valid) n_state = pdga_pkg::S_MAP_X;
            end
            pdga_pkg::S_MAP_X:     n_state = pdga_pkg::S_MAP_Y;
            pdga_pkg::S_MAP_Y:     n_state = pdga_pkg::S_MAP_ROW;
            pdga_pkg::S_MAP_ROW:   n_state = pdga_pkg::S_CTR_READ;
            pdga_pkg::S_CTR_READ:  n_state = pdga_pkg::S_CTR_CHECK;
            pdga_pkg::S_CTR_CHECK: begin
                n_state = own_hit ? pdga_pkg::S_FINISH : pdga_pkg::S_NBR_ADDR;
            end
            pdga_pkg::S_NBR_ADDR: begin
                if (nb_inside) begin
                    n_state = pdga_pkg::S_NBR_OWNER;
                end else if (r_k == 3'd7) begin
                    n_state = pdga_pkg::S_DECIDE;
                end
            end
            pdga_pkg::S_NBR_OWNER: begin
                if (own_hit) begin
                    n_state = pdga_pkg::S_NBR_DIFF;
                end else if (r_k == 3'd7) begin
                    n_state = pdga_pkg::S_DECIDE;
                end else begin
                    n_state = pdga_pkg::S_NBR_ADDR;
                end
            end
            pdga_pkg::S_NBR_DIFF:  n_state = pdga_pkg::S_NBR_SQX;
            pdga_pkg::S_NBR_SQX:   n_state = pdga_pkg::S_NBR_SQY;
            pdga_pkg::S_NBR_SQY:   n_state = pdga_pkg::S_NBR_CMP;
            pdga_pkg::S_NBR_CMP: begin
                if (dist_sum < {1'b0, r_dist_limit}) begin
                    n_state = pdga_pkg::S_FINISH;
                end else if (r_k == 3'd7) begin
                    n_state = pdga_pkg::S_DECIDE;
                end else begin
                    n_state = pdga_pkg::S_NBR_ADDR;
                end
            end
            pdga_pkg::S_DECIDE:    n_state = pdga_pkg::S_FINISH;
            pdga_pkg::S_FINISH: begin
                if (out_free) n_state = pdga_pkg::S_IDLE;
            end
            default:               n_state = pdga_pkg::S_IDLE;
        endcase
    end

    // Datapath control for each state.
    always_comb begin
        mul_a       = r_x;
        mul_b       = r_cell_scale;
        own_rd_addr = ctr_addr;
        own_we      = 1'b0;
        own_wr_addr = ctr_addr;
        own_wr_data = {1'b1, r_count[IW-1:0]};
        smp_we      = 1'b0;
        ld_col      = 1'b0;
        ld_row      = 1'b0;
        ld_diff     = 1'b0;
        ld_acc      = 1'b0;
        set_status  = 1'b0;
        status_val  = pdga_pkg::ST_ACCEPT;
        k_clear     = 1'b0;
        k_step      = 1'b0;
        cnt_inc     = 1'b0;
        out_load    = 1'b0;
        o_cand_stall = (r_state != pdga_pkg::S_IDLE);
        unique case (r_state)
            pdga_pkg::S_CLEAR: begin
                own_we      = 1'b1;
                own_wr_addr = r_clr;
                own_wr_data = '0;
            end
            pdga_pkg::S_MAP_X: begin
                mul_a = r_x;
            end
            pdga_pkg::S_MAP_Y: begin
                mul_a  = r_y;
                ld_col = 1'b1;
            end
            pdga_pkg::S_MAP_ROW: begin
                ld_row = 1'b1;
            end
            pdga_pkg::S_CTR_READ: begin
                own_rd_addr = ctr_addr;
            end
            pdga_pkg::S_CTR_CHECK: begin
                k_clear    = 1'b1;
                set_status = 1'b1;
                status_val = own_hit ? pdga_pkg::ST_OCCUPIED : pdga_pkg::ST_ACCEPT;
            end
            pdga_pkg::S_NBR_ADDR: begin
                own_rd_addr = nb_addr;
                k_step      = !nb_inside;
            end
            pdga_pkg::S_NBR_OWNER: begin
                k_step = !own_hit;
            end
            pdga_pkg::S_NBR_DIFF: begin
                ld_diff = 1'b1;
            end
            pdga_pkg::S_NBR_SQX: begin
                mul_a = r_dx;
                mul_b = {6'd0, r_dx};
            end
            pdga_pkg::S_NBR_SQY: begin
                mul_a  = r_dy;
                mul_b  = {6'd0, r_dy};
                ld_acc = 1'b1;
            end
            pdga_pkg::S_NBR_CMP: begin
                if (dist_sum < {1'b0, r_dist_limit}) begin
                    set_status = 1'b1;
                    status_val = pdga_pkg::ST_CLOSE;
                end else begin
                    k_step = 1'b1;
                end
            end
            pdga_pkg::S_DECIDE: begin
                set_status = 1'b1;
                if (store_full) begin
                    status_val = pdga_pkg::ST_FULL;
                end else begin
                    status_val = pdga_pkg::ST_ACCEPT;
                    own_we     = 1'b1;
                    smp_we     = 1'b1;
                end
            end
            pdga_pkg::S_FINISH: begin
                out_load = out_free;
            end
            default: begin
                mul_a = r_x;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_dim     <= pdga_pkg::GRID_DIM_RST;
            r_cell_scale   <= pdga_pkg::CELL_SCALE_RST;
            r_dist_limit   <= pdga_pkg::DIST_LIMIT_RST;
            r_sample_limit <= pdga_pkg::SAMPLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdga_pkg::CFG_GRID_DIM:     r_grid_dim     <= i_cfg_data[6:0];
                pdga_pkg::CFG_CELL_SCALE:   r_cell_scale   <= i_cfg_data[22:0];
                pdga_pkg::CFG_DIST_LIMIT:   r_dist_limit   <= i_cfg_data;
                pdga_pkg::CFG_SAMPLE_LIMIT: r_sample_limit <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Control registers: state, clearing pass, neighbor counter, sample count, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdga_pkg::S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pdga_pkg::S_CLEAR) r_clr <= r_clr + AW'(1);
            if (k_clear) begin
                r_k <= '0;
            end else if (k_step) begin
                r_k <= r_k + 3'd1;
            end
            if (cnt_inc || smp_we) r_count <= r_count + NW'(1);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge i_clk) begin
        if (r_state == pdga_pkg::S_IDLE && i_cand_valid) begin
            r_x <= i_cand_x;
            r_y <= i_cand_y;
        end
        r_prod <= w_prod;
        if (ld_col) r_col <= sat_cell[CW-1:0];
        if (ld_row) r_row <= sat_cell[CW-1:0];
        if (ld_diff) begin
            r_dx <= abs_dx;
            r_dy <= abs_dy;
        end
        if (ld_acc) r_acc <= r_prod[33:0];
        if (set_status) r_status <= status_val;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_accepted <= (r_status == pdga_pkg::ST_ACCEPT);
            r_out_status   <= r_status;
            // The count has already moved past the new sample when accepted.
            r_out_index    <= (r_status == pdga_pkg::ST_ACCEPT)
                              ? 12'(r_count - NW'(1)) : 12'd0;
            r_out_col      <= 6'(r_col);
            r_out_row      <= 6'(r_row);
        end
    end

    // Cell-owner memory: valid bit and sample index per cell.
    always_ff @(posedge i_clk) begin
        if (own_we) r_owner[own_wr_addr] <= own_wr_data;
        r_own_rd <= r_owner[own_rd_addr];
    end

    // Sample memory: x and y of each stored sample.
    always_ff @(posedge i_clk) begin
        if (smp_we) r_store[r_count[IW-1:0]] <= {r_x, r_y};
        r_smp_rd <= r_store[r_own_rd[IW-1:0]];
    end

    assign o_res_valid    = r_out_valid;
    assign o_accepted     = r_out_accepted;
    assign o_status       = r_out_status;
    assign o_sample_index = r_out_index;
    assign o_cell_col     = r_out_col;
    assign o_cell_row     = r_out_row;

endmodule

`default_nettype wire

### tb/sv/tb_poisson_disk_grid_accept_core.sv
// ============================================================================
// tb_poisson_disk_grid_accept_core: self-checking bench for the grid accept core
// Sends candidate points through the valid/stall channel and tracks the cell
// owners, stored samples and sample count in a local model of the block.
// Each result is checked field by field against the oldest predicted result.
// A short directed part covers the edge cases. Several random phases follow,
// each with its own grid, scale, threshold and sample-limit setting. Sender
// bursts, receiver stall patterns and one long receiver hold-off are applied.
// ============================================================================
module tb_poisson_disk_grid_accept_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_SIDE = 64;
    localparam int STORE_DEPTH = 4096;
    localparam int PHASE_ITEMS = 110;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER = 200;
    localparam int STUCK_LIMIT = 20000;

    typedef struct packed {
        logic [16:0] x;
        logic [16:0] y;
    } t_cand;

    typedef struct packed {
        logic              accepted;
        pdga_pkg::t_status status;
        logic [11:0]       sample_index;
        logic [5:0]        cell_col;
        logic [5:0]        cell_row;
    } t_grid_result;

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [33:0] i_cfg_data = '0;
    logic        i_cand_valid = 1'b0;
    logic [16:0] i_cand_x = '0;
    logic [16:0] i_cand_y = '0;
    logic        i_res_stall = 1'b0;

    logic        o_cand_stall;
    logic        o_res_valid;
    logic        o_accepted;
    logic [1:0]  o_status;
    logic [11:0] o_sample_index;
    logic [5:0]  o_cell_col;
    logic [5:0]  o_cell_row;

    poisson_disk_grid_accept_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cand_valid   (i_cand_valid),
        .o_cand_stall   (o_cand_stall),
        .i_cand_x       (i_cand_x),
        .i_cand_y       (i_cand_y),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_accepted     (o_accepted),
        .o_status       (o_status),
        .o_sample_index (o_sample_index),
        .o_cell_col     (o_cell_col),
        .o_cell_row     (o_cell_row)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the grid, the sample store and the configuration.
    bit          owner_valid [GRID_SIDE*GRID_SIDE];
    int unsigned owner_index [GRID_SIDE*GRID_SIDE];
    logic [16:0] store_x [STORE_DEPTH];
    logic [16:0] store_y [STORE_DEPTH];
    int unsigned stored_count = 0;

    logic [6:0]  cfg_dim = pdga_pkg::GRID_DIM_RST;
    logic [22:0] cfg_scale = pdga_pkg::CELL_SCALE_RST;
    logic [33:0] cfg_dist = pdga_pkg::DIST_LIMIT_RST;
    logic [12:0] cfg_limit = pdga_pkg::SAMPLE_LIMIT_RST;

    t_cand        cand_pending [$];
    t_grid_result grid_expect [$];

    int  requests_queued = 0;
    int  requests_taken = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  stored_n = 0;
    int  occupied_n = 0;
    int  close_n = 0;
    int  full_n = 0;
    int  settings_n = 0;
    bit  cand_taken = 1'b0;
    logic [16:0] last_x = '0;
    logic [16:0] last_y = '0;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Grid cell of one coordinate, saturated to the last cell in use.
    function automatic int unsigned grid_cell(input logic [16:0] coord, input int unsigned dim);
        logic [63:0] scaled;
        scaled = (64'(coord) * 64'(cfg_scale)) >> 32;
        return (scaled > 64'(dim - 1)) ? dim - 1 : int'(scaled);
    endfunction

    // Decide one candidate and update the local grid and store on acceptance.
    function automatic t_grid_result place_candidate(input logic [16:0] x, input logic [16:0] y);
        t_grid_result r;
        int unsigned  dim;
        int unsigned  cap;
        int unsigned  col;
        int unsigned  row;
        int unsigned  nb_cell;
        int unsigned  s;
        int           nc;
        int           nr;
        bit           too_close;
        logic [16:0]  dx;
        logic [16:0]  dy;
        logic [63:0]  d2;
        r = '0;
        too_close = 1'b0;
        dim = (cfg_dim == 0) ? 1 : (cfg_dim > GRID_SIDE) ? GRID_SIDE : cfg_dim;
        cap = (cfg_limit == 0) ? 1 : (cfg_limit > STORE_DEPTH) ? STORE_DEPTH : cfg_limit;
        col = grid_cell(x, dim);
        row = grid_cell(y, dim);
        r.cell_col = col[5:0];
        r.cell_row = row[5:0];
        if (owner_valid[row*GRID_SIDE + col]) begin
            r.status = pdga_pkg::ST_OCCUPIED;
        end else begin
            // Walk the eight neighbors that lie inside the grid in use.
            for (int dj = -1; dj <= 1 && !too_close; dj++) begin
                for (int di = -1; di <= 1 && !too_close; di++) begin
                    nc = int'(col) + di;
                    nr = int'(row) + dj;
                    if (!(di == 0 && dj == 0) && nc >= 0 && nc < int'(dim)
                            && nr >= 0 && nr < int'(dim)) begin
                        nb_cell = nr*GRID_SIDE + nc;
                        if (owner_valid[nb_cell]) begin
                            s = owner_index[nb_cell] % STORE_DEPTH;
                            dx = (x >= store_x[s]) ? x - store_x[s] : store_x[s] - x;
                            dy = (y >= store_y[s]) ? y - store_y[s] : store_y[s] - y;
                            d2 = 64'(dx)*64'(dx) + 64'(dy)*64'(dy);
                            if (d2 < 64'(cfg_dist))
                                too_close = 1'b1;
                        end
                    end
                end
            end
            if (too_close) begin
                r.status = pdga_pkg::ST_CLOSE;
            end else if (stored_count >= cap) begin
                r.status = pdga_pkg::ST_FULL;
            end else begin
                r.status = pdga_pkg::ST_ACCEPT;
                r.accepted = 1'b1;
                r.sample_index = stored_count[11:0];
                store_x[stored_count] = x;
                store_y[stored_count] = y;
                owner_valid[row*GRID_SIDE + col] = 1'b1;
                owner_index[row*GRID_SIDE + col] = stored_count;
                stored_count++;
            end
        end
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge i_clk) begin : send_proc
        t_cand item;
        if (!i_cand_valid || cand_taken) begin
            if (gap_left != 0) begin
                i_cand_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cand_pending.size() != 0) begin
                item = cand_pending.pop_front();
                i_cand_valid <= 1'b1;
                i_cand_x <= item.x;
                i_cand_y <= item.y;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_cand_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall modes that change now and then, plus one long hold-off.
    int  stall_mode = 0;
    int  mode_left = 100;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;

    always @(negedge i_clk) begin : recv_proc
        if (hold_left != 0) begin
            i_res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            i_res_stall <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_res_stall <= 1'b0;
                1: i_res_stall <= ($urandom_range(0, 3) == 0);
                2: i_res_stall <= ($urandom_range(0, 3) != 0);
                default: i_res_stall <= (mode_left % 3 == 0);
            endcase
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(50, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
        end
    end

    // Monitor: predicts accepted requests, checks results, watches for a hang.
    int stuck_cycles = 0;

    always @(posedge i_clk) begin : watch_proc
        t_grid_result want;
        bit           moved;
        moved = 1'b0;
        cand_taken <= i_rst_n && i_cand_valid && (o_cand_stall === 1'b0);
        if (i_rst_n) begin
            if (o_res_valid === 1'b1 && !i_res_stall) begin
                moved = 1'b1;
                results_seen++;
                if (grid_expect.size() == 0) begin
                    flag_mismatch("result arrived with no request outstanding");
                end else begin
                    want = grid_expect.pop_front();
                    if (o_accepted !== want.accepted)
                        flag_mismatch($sformatf("accepted want %0d got %0d",
                                                want.accepted, o_accepted));
                    if (o_status !== want.status)
                        flag_mismatch($sformatf("status want %0d got %0d",
                                                want.status, o_status));
                    if (o_sample_index !== want.sample_index)
                        flag_mismatch($sformatf("sample_index want %0d got %0d",
                                                want.sample_index, o_sample_index));
                    if (o_cell_col !== want.cell_col)
                        flag_mismatch($sformatf("cell_col want %0d got %0d",
                                                want.cell_col, o_cell_col));
                    if (o_cell_row !== want.cell_row)
                        flag_mismatch($sformatf("cell_row want %0d got %0d",
                                                want.cell_row, o_cell_row));
                end
            end
            if (i_cand_valid && o_cand_stall === 1'b0) begin
                moved = 1'b1;
                requests_taken++;
                want = place_candidate(i_cand_x, i_cand_y);
                case (want.status)
                    pdga_pkg::ST_ACCEPT:   stored_n++;
                    pdga_pkg::ST_OCCUPIED: occupied_n++;
                    pdga_pkg::ST_CLOSE:    close_n++;
                    default:               full_n++;
                endcase
                grid_expect.push_back(want);
            end
        end
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", STUCK_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_cand(input logic [16:0] x, input logic [16:0] y);
        cand_pending.push_back('{x: x, y: y});
        requests_queued++;
        last_x = x;
        last_y = y;
    endtask

    // Wait until every request is taken and answered, then let the block settle.
    task automatic wait_drained();
        while (requests_taken != requests_queued || grid_expect.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input pdga_pkg::t_cfg_index idx, input logic [33:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
    endtask

    // Program all four registers while the block is idle.
    task automatic load_config(input logic [6:0] dim, input logic [22:0] scale,
                               input logic [33:0] dist_lim, input logic [12:0] limit);
        wait_drained();
        write_reg(pdga_pkg::CFG_GRID_DIM, 34'(dim));
        write_reg(pdga_pkg::CFG_CELL_SCALE, 34'(scale));
        write_reg(pdga_pkg::CFG_DIST_LIMIT, dist_lim);
        write_reg(pdga_pkg::CFG_SAMPLE_LIMIT, 34'(limit));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_dim = dim;
        cfg_scale = scale;
        cfg_dist = dist_lim;
        cfg_limit = limit;
        settings_n++;
    endtask

    // Mostly points in the unit square, some near the last point, a few
    // beyond 1.0 or on the corners.
    function automatic logic [16:0] pick_coord(input logic [16:0] prev);
        int v;
        case ($urandom_range(0, 19))
            0: begin
                case ($urandom_range(0, 2))
                    0: v = 0;
                    1: v = 65536;
                    default: v = 17'h1FFFF;
                endcase
            end
            1, 2: v = $urandom_range(0, 17'h1FFFF);
            3, 4, 5, 6, 7, 8: begin
                v = int'(prev) + $urandom_range(0, 6000) - 3000;
                if (v < 0) v = 0;
                if (v > 17'h1FFFF) v = 17'h1FFFF;
            end
            default: v = $urandom_range(0, 65536);
        endcase
        return v[16:0];
    endfunction

    task automatic random_phase(input logic [6:0] dim, input logic [22:0] scale,
                                input logic [33:0] dist_lim, input logic [12:0] limit,
                                input int count);
        logic [16:0] x;
        logic [16:0] y;
        load_config(dim, scale, dist_lim, limit);
        for (int k = 0; k < count; k++) begin
            x = pick_coord(last_x);
            y = pick_coord(last_y);
            push_cand(x, y);
        end
    endtask

    initial begin : stim_proc
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, repeats and coordinates above 1.0.
        push_cand(17'd0, 17'd0);
        push_cand(17'd0, 17'd0);
        push_cand(17'd65536, 17'd65536);
        push_cand(17'h1FFFF, 17'h1FFFF);
        push_cand(17'h1FFFF, 17'd0);
        push_cand(17'd1024, 17'd0);

        // Threshold: one neighbor just inside, one exactly on the limit.
        load_config(7'd64, 23'd4194304, 34'd2250000, 13'd4096);
        push_cand(17'd5000, 17'd5000);
        push_cand(17'd5000, 17'd3600);
        push_cand(17'd5000, 17'd3500);

        // Limit of zero acts as one: store full, and the rejection priority.
        load_config(7'd64, 23'd4194304, 34'd2250000, 13'd0);
        push_cand(17'd40000, 17'd40000);
        push_cand(17'd5000, 17'd5000);
        push_cand(17'd5000, 17'd6000);

        // Grid size zero acts as one cell; largest scale.
        load_config(7'd0, 23'h7FFFFF, 34'd0, 13'h1FFF);
        push_cand(17'd30000, 17'd30000);
        push_cand(17'h1FFFF, 17'd12345);

        // Grid shrunk after use: far points saturate into a 4x4 grid.
        load_config(7'd4, 23'd4194304, 34'd1000000, 13'h1FFF);
        push_cand(17'd60000, 17'd60000);
        push_cand(17'd0, 17'd65536);
        push_cand(17'd20000, 17'd65536);

        // Scale zero maps every point to the first cell.
        load_config(7'd64, 23'd0, 34'd0, 13'h1FFF);
        push_cand(17'd65536, 17'd65536);

        // Grid size above the maximum, largest threshold.
        load_config(7'd127, 23'd4194304, 34'h3FFFFFFFF, 13'd4096);
        push_cand(17'd2000, 17'd2000);
        push_cand(17'd30000, 17'd65536);
        push_cand(17'd45000, 17'd20000);

        // Random phases over a range of settings.
        random_phase(7'd8, 23'd524288, 34'd42949673, 13'h1FFF, PHASE_ITEMS);
        random_phase(7'd16, 23'd1048576, 34'($urandom_range(0, 1 << 28)), 13'd4096,
                     PHASE_ITEMS);
        random_phase(7'd127, 23'h7FFFFF, 34'h3FFFFFFFF, 13'($urandom_range(1, 8191)),
                     PHASE_ITEMS);
        random_phase(7'd64, 23'($urandom_range(0, 23'h7FFFFF)),
                     34'($urandom_range(0, 1 << 26)), 13'h1FFF, PHASE_ITEMS);
        random_phase(7'd1, 23'd4194304, 34'd0, 13'h1FFF, PHASE_ITEMS / 3);
        random_phase(7'd32, 23'd2097152, 34'd10737418, 13'(stored_count + 15), PHASE_ITEMS);
        random_phase(7'd64, 23'd4194304, 34'd4194304, 13'h1FFF, PHASE_ITEMS);
        random_phase(7'd2, 23'd131072, 34'd0, 13'd0, PHASE_ITEMS / 3);

        wait_drained();
        if (grid_expect.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", grid_expect.size()));

        $display("Checked %0d candidates: %0d stored, %0d cell taken, %0d too close, %0d full.",
                 requests_taken, stored_n, occupied_n, close_n, full_n);
        $display("Swept %0d register settings, including grid, scale and limit extremes.",
                 settings_n);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
